// ----- rtl/core/seeds_pkg.sv -----
// Shared constants, types and helpers for the Seeds torus automaton.
// No dependencies.
package seeds_pkg;

  localparam int ROWS_MAX = 64;
  localparam int COLS_MAX = 64;
  localparam int ROW_AW   = $clog2(ROWS_MAX);
  localparam int COL_AW   = $clog2(COLS_MAX);
  localparam int EXT_W    = 7;
  localparam int CNT_W    = 4;

  localparam logic [EXT_W-1:0] MIN_EXTENT  = EXT_W'(3);
  localparam logic [EXT_W-1:0] ROWS_LIMIT  = EXT_W'(ROWS_MAX);
  localparam logic [EXT_W-1:0] COLS_LIMIT  = EXT_W'(COLS_MAX);
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(2);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef logic [COLS_MAX-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_PRE0,
    ST_PRE1,
    ST_PRE2,
    ST_ROW,
    ST_DONE
  } state_t;

  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v,
                                                    input logic [EXT_W-1:0] maxv);
    logic [EXT_W-1:0] res;
    if (v < MIN_EXTENT) begin
      res = MIN_EXTENT;
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/seeds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module seeds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/seeds_row_unit.sv -----
// One-row Seeds (B2/S) update: a lane per column with wrapped neighbors.
// Depends on seeds_pkg.
module seeds_row_unit (
  input  seeds_pkg::row_t                 prev_row,
  input  seeds_pkg::row_t                 cur_row,
  input  seeds_pkg::row_t                 next_row,
  input  logic [seeds_pkg::EXT_W-1:0]     cols,
  output seeds_pkg::row_t                 new_row
);

  logic [seeds_pkg::COL_AW-1:0] last_col;
  seeds_pkg::row_t              pl, pr, cl, cr, nl, nr;
  logic [seeds_pkg::CNT_W-1:0]  cnt [seeds_pkg::COLS_MAX];

  assign last_col = seeds_pkg::COL_AW'(cols - seeds_pkg::EXT_W'(1));

  always_comb begin
    for (int c = 0; c < seeds_pkg::COLS_MAX; c++) begin
      if (c == 0) begin
        pl[c] = prev_row[last_col];
        cl[c] = cur_row[last_col];
        nl[c] = next_row[last_col];
      end else begin
        pl[c] = prev_row[c-1];
        cl[c] = cur_row[c-1];
        nl[c] = next_row[c-1];
      end
      if (c == seeds_pkg::COLS_MAX - 1 || seeds_pkg::COL_AW'(c) == last_col) begin
        pr[c] = prev_row[0];
        cr[c] = cur_row[0];
        nr[c] = next_row[0];
      end else begin
        pr[c] = prev_row[c+1];
        cr[c] = cur_row[c+1];
        nr[c] = next_row[c+1];
      end
      cnt[c] = seeds_pkg::CNT_W'(pl[c]) + seeds_pkg::CNT_W'(prev_row[c])
             + seeds_pkg::CNT_W'(pr[c]) + seeds_pkg::CNT_W'(cl[c])
             + seeds_pkg::CNT_W'(cr[c]) + seeds_pkg::CNT_W'(nl[c])
             + seeds_pkg::CNT_W'(next_row[c]) + seeds_pkg::CNT_W'(nr[c]);
      if (seeds_pkg::EXT_W'(c) < cols) begin
        new_row[c] = (cnt[c] == seeds_pkg::BIRTH_COUNT);
      end else begin
        new_row[c] = cur_row[c];
      end
    end
  end

endmodule

// ----- rtl/core/seeds_automaton_torus_step_top.sv -----
// Seeds (B2/S) automaton on a wrapped grid: cell write/read and generation step.
// Cell write/read: accepted in ST_IDLE, result registered from ST_CELL. Step: preload in
// ST_PRE0, ST_PRE1, ST_PRE2, then one grid row per cycle in ST_ROW through the shared row
// unit and one RAM port pair, result from ST_DONE. No new item is taken until idle. A stalled result
// holds the item. Synchronous active-low reset: all cells dead (per-row valid bits),
// extents 64, idle. Depends on seeds_pkg, seeds_ram, seeds_row_unit.
module seeds_automaton_torus_step_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [seeds_pkg::EXT_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [seeds_pkg::ROW_AW-1:0]  in_row,
  input  logic [seeds_pkg::COL_AW-1:0]  in_col,
  input  logic                          in_alive_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_alive_out,
  output logic                          out_bad_coordinate
);

  seeds_pkg::state_t state_r, state_nxt;

  logic [seeds_pkg::EXT_W-1:0]  rows_r, cols_r;
  logic [seeds_pkg::ROWS_MAX-1:0] valid_r, valid_nxt;
  logic                         rd_valid_r;

  seeds_pkg::cmd_t              cmd_r;
  logic [seeds_pkg::ROW_AW-1:0] row_r, row_nxt;
  logic [seeds_pkg::COL_AW-1:0] col_r;
  logic                         alive_r;
  logic                         bad_r;

  seeds_pkg::row_t prev_r, prev_nxt, cur_r, cur_nxt, row0_r, row0_nxt;
  seeds_pkg::row_t rdata, rdata_m, next_row, new_row, wdata, cell_word;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_alive_r, out_alive_nxt;
  logic                         out_bad_r, out_bad_nxt;

  logic                         we;
  logic [seeds_pkg::ROW_AW-1:0] waddr, raddr;
  logic                         out_free, accept, last_row;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == seeds_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign rdata_m   = rd_valid_r ? rdata : '0;
  assign last_row  = (seeds_pkg::EXT_W'(row_r) + seeds_pkg::EXT_W'(1) == rows_r);
  assign next_row  = last_row ? row0_r : rdata_m;

  assign out_valid          = out_valid_r;
  assign out_alive_out      = out_alive_r;
  assign out_bad_coordinate = out_bad_r;

  always_comb begin
    cell_word        = rdata_m;
    cell_word[col_r] = alive_r;
  end

  seeds_ram #(
    .WIDTH (seeds_pkg::COLS_MAX),
    .DEPTH (seeds_pkg::ROWS_MAX)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  seeds_row_unit u_row (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (next_row),
    .cols     (cols_r),
    .new_row  (new_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= seeds_pkg::ST_IDLE;
      rows_r      <= seeds_pkg::ROWS_LIMIT;
      cols_r      <= seeds_pkg::COLS_LIMIT;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_valid_r  <= valid_r[raddr];
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == seeds_pkg::REG_ROWS) begin
        rows_r <= seeds_pkg::clamp_extent(cfg_wdata, seeds_pkg::ROWS_LIMIT);
      end
      if (cfg_we && cfg_index == seeds_pkg::REG_COLS) begin
        cols_r <= seeds_pkg::clamp_extent(cfg_wdata, seeds_pkg::COLS_LIMIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= seeds_pkg::cmd_t'(in_command);
      col_r   <= in_col;
      alive_r <= in_alive_in;
      bad_r   <= (seeds_pkg::EXT_W'(in_row) >= rows_r) ||
                 (seeds_pkg::EXT_W'(in_col) >= cols_r);
    end
    row_r       <= row_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    row0_r      <= row0_nxt;
    out_alive_r <= out_alive_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    row_nxt       = row_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    row0_nxt      = row0_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_alive_nxt = out_alive_r;
    out_bad_nxt   = out_bad_r;
    we            = 1'b0;
    waddr         = row_r;
    wdata         = new_row;
    raddr         = '0;
    case (state_r)
      seeds_pkg::ST_IDLE: begin
        raddr = in_row;
        if (accept) begin
          row_nxt = in_row;
          if (seeds_pkg::cmd_t'(in_command) == seeds_pkg::CMD_STEP) begin
            state_nxt = seeds_pkg::ST_PRE0;
          end else begin
            state_nxt = seeds_pkg::ST_CELL;
          end
        end
      end
      seeds_pkg::ST_CELL: begin
        raddr = row_r;
        wdata = cell_word;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = 1'b0;
          out_alive_nxt = 1'b0;
          state_nxt     = seeds_pkg::ST_IDLE;
          case (cmd_r)
            seeds_pkg::CMD_WRITE: begin
              out_bad_nxt = bad_r;
              if (!bad_r) begin
                we               = 1'b1;
                valid_nxt[row_r] = 1'b1;
                out_alive_nxt    = alive_r;
              end
            end
            seeds_pkg::CMD_READ: begin
              out_bad_nxt   = bad_r;
              out_alive_nxt = !bad_r && rdata_m[col_r];
            end
            default: begin
            end
          endcase
        end
      end
      seeds_pkg::ST_PRE0: begin
        raddr     = seeds_pkg::ROW_AW'(rows_r - seeds_pkg::EXT_W'(1));
        state_nxt = seeds_pkg::ST_PRE1;
      end
      seeds_pkg::ST_PRE1: begin
        raddr     = '0;
        prev_nxt  = rdata_m;
        state_nxt = seeds_pkg::ST_PRE2;
      end
      seeds_pkg::ST_PRE2: begin
        raddr     = seeds_pkg::ROW_AW'(1);
        cur_nxt   = rdata_m;
        row0_nxt  = rdata_m;
        row_nxt   = '0;
        state_nxt = seeds_pkg::ST_ROW;
      end
      seeds_pkg::ST_ROW: begin
        raddr            = row_r + seeds_pkg::ROW_AW'(2);
        we               = 1'b1;
        valid_nxt[row_r] = 1'b1;
        prev_nxt         = cur_r;
        cur_nxt          = next_row;
        row_nxt          = row_r + seeds_pkg::ROW_AW'(1);
        if (last_row) begin
          state_nxt = seeds_pkg::ST_DONE;
        end
      end
      seeds_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = 1'b0;
          out_bad_nxt   = 1'b0;
          state_nxt     = seeds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = seeds_pkg::ST_IDLE;
      end
    endcase
  end

  a_extent_range: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r >= seeds_pkg::MIN_EXTENT && rows_r <= seeds_pkg::ROWS_LIMIT &&
    cols_r >= seeds_pkg::MIN_EXTENT && cols_r <= seeds_pkg::COLS_LIMIT)
    else $error("extent register out of range");

  a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == seeds_pkg::ST_ROW |-> seeds_pkg::EXT_W'(row_r) < rows_r)
    else $error("step row counter beyond rows in use");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> valid_r[$past(waddr)])
    else $error("written row not marked valid");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != seeds_pkg::ST_IDLE) && (state_nxt == seeds_pkg::ST_IDLE)
      |=> out_valid_r)
    else $error("item finished without a result");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for seeds_automaton_torus_step_top: cell write/read, grid steps
// and extent registers, checked against a behavioral torus model kept in the bench.
// Depends on seeds_pkg and the RTL top level only.
module tb_top;
  import seeds_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = ROWS_MAX + 16;

  typedef struct packed {
    logic alive;
    logic bad;
  } cell_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_ROWS;
  logic [EXT_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = CMD_NONE;
  logic [ROW_AW-1:0]  in_row = '0;
  logic [COL_AW-1:0]  in_col = '0;
  logic               in_alive_in = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_alive_out;
  logic               out_bad_coordinate;

  bit [COLS_MAX-1:0]  cell_grid [2][ROWS_MAX];
  bit                 live_bank = 1'b0;
  int                 rows_used = ROWS_MAX;
  int                 cols_used = COLS_MAX;
  cell_result_t       pending_cells [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  random_sent = 0;
  int  burst_left = 0;
  bit  sender_steady = 1'b1;
  bit  rx_open = 1'b0;
  bit  rx_stall = 1'b0;
  int  rx_left = 0;

  seeds_automaton_torus_step_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_row             (in_row),
    .in_col             (in_col),
    .in_alive_in        (in_alive_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_alive_out      (out_alive_out),
    .out_bad_coordinate (out_bad_coordinate)
  );

  always #2 clk = ~clk;

  // ---------------- torus model ----------------
  function automatic int bound_extent(input logic [EXT_W-1:0] v, input int top);
    int res;
    res = int'(v);
    if (res < 3) res = 3;
    else if (res > top) res = top;
    return res;
  endfunction

  function automatic int cell_at(input bit bank, input int r, input int c);
    return int'(cell_grid[bank][r][c]);
  endfunction

  function automatic void advance_generation();
    int rn, rs, cw, ce, cnt;
    bit nxt;
    nxt = ~live_bank;
    for (int r = 0; r < ROWS_MAX; r++) cell_grid[nxt][r] = cell_grid[live_bank][r];
    for (int r = 0; r < rows_used; r++) begin
      rn = (r == 0) ? rows_used - 1 : r - 1;
      rs = (r + 1 == rows_used) ? 0 : r + 1;
      for (int c = 0; c < cols_used; c++) begin
        cw = (c == 0) ? cols_used - 1 : c - 1;
        ce = (c + 1 == cols_used) ? 0 : c + 1;
        cnt = cell_at(live_bank, rn, cw) + cell_at(live_bank, rn, c) + cell_at(live_bank, rn, ce)
            + cell_at(live_bank, r, cw) + cell_at(live_bank, r, ce)
            + cell_at(live_bank, rs, cw) + cell_at(live_bank, rs, c) + cell_at(live_bank, rs, ce);
        cell_grid[nxt][r][c] = (cnt == 2);
      end
    end
    live_bank = nxt;
  endfunction

  function automatic void predict_item(input cmd_t cmd, input logic [ROW_AW-1:0] row,
                                       input logic [COL_AW-1:0] col, input logic alive);
    cell_result_t res;
    res = '0;
    if (cmd == CMD_WRITE || cmd == CMD_READ) begin
      if (int'(row) >= rows_used || int'(col) >= cols_used) begin
        res.bad = 1'b1;
      end else if (cmd == CMD_WRITE) begin
        cell_grid[live_bank][row][col] = alive;
        res.alive = alive;
      end else begin
        res.alive = cell_grid[live_bank][row][col];
      end
    end else if (cmd == CMD_STEP) begin
      advance_generation();
    end
    pending_cells.push_back(res);
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0d] mismatch: %s got %b want %b", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected item, alive_out", out_alive_out, 1'b0);
      end else begin
        want = pending_cells.pop_front();
        if (out_alive_out !== want.alive)
          report_mismatch("alive_out", out_alive_out, want.alive);
        if (out_bad_coordinate !== want.bad)
          report_mismatch("bad_coordinate", out_bad_coordinate, want.bad);
      end
    end
  end

  // ---------------- receiver stalls ----------------
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_stall = ($urandom_range(0, 2) == 0);
      rx_left = rx_stall ? $urandom_range(1, 8) : $urandom_range(1, 30);
    end
    rx_left--;
    out_ready <= !rx_stall || rx_open;
  end

  // ---------------- driving ----------------
  task automatic send_item(input cmd_t cmd, input logic [ROW_AW-1:0] row,
                           input logic [COL_AW-1:0] col, input logic alive);
    int gap;
    gap = 0;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_row      <= row;
    in_col      <= col;
    in_alive_in <= alive;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(cmd, row, col, alive);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_extent(input logic idx, input logic [EXT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROWS) rows_used = bound_extent(value, ROWS_MAX);
    else cols_used = bound_extent(value, COLS_MAX);
  endtask

  task automatic set_grid(input logic [EXT_W-1:0] rows, input logic [EXT_W-1:0] cols);
    settle();
    write_extent(REG_ROWS, rows);
    write_extent(REG_COLS, cols);
  endtask

  // ---------------- tests ----------------
  task automatic test_corner_cells();
    sender_steady = 1'b1;
    send_item(CMD_READ, 0, 0, 1'b1);
    send_item(CMD_READ, 63, 63, 1'b0);
    send_item(CMD_WRITE, 0, 0, 1'b1);
    send_item(CMD_WRITE, 63, 63, 1'b1);
    send_item(CMD_WRITE, 0, 63, 1'b1);
    send_item(CMD_WRITE, 63, 0, 1'b0);
    send_item(CMD_WRITE, 42, 21, 1'b1);
    send_item(CMD_WRITE, 42, 21, 1'b0);
    send_item(CMD_READ, 0, 0, 1'b0);
    send_item(CMD_READ, 63, 63, 1'b0);
    send_item(CMD_READ, 42, 21, 1'b1);
    send_item(CMD_NONE, 63, 63, 1'b1);
    send_item(CMD_READ, 0, 0, 1'b0);
    send_item(CMD_STEP, 0, 0, 1'b0);
    send_item(CMD_READ, 63, 62, 1'b0);
    send_item(CMD_READ, 1, 62, 1'b0);
    send_item(CMD_READ, 0, 62, 1'b0);
    send_item(CMD_READ, 62, 0, 1'b0);
    send_item(CMD_READ, 0, 0, 1'b0);
    send_item(CMD_STEP, 63, 63, 1'b1);
    send_item(CMD_READ, 63, 0, 1'b0);
    send_item(CMD_READ, 1, 1, 1'b0);
  endtask

  task automatic test_extent_limits();
    logic [EXT_W-1:0] rset [6] = '{7'd0, 7'd2, 7'd3, 7'd64, 7'd3, 7'd127};
    logic [EXT_W-1:0] cset [6] = '{7'd127, 7'd65, 7'd3, 7'd3, 7'd64, 7'd0};
    sender_steady = 1'b0;
    for (int i = 0; i < 6; i++) begin
      set_grid(rset[i], cset[i]);
      send_item(CMD_READ, ROW_AW'(rows_used - 1), COL_AW'(cols_used - 1), 1'b0);
      send_item(CMD_WRITE, ROW_AW'(rows_used % ROWS_MAX), 0, 1'b1);
      send_item(CMD_WRITE, 0, COL_AW'(cols_used % COLS_MAX), 1'b1);
      send_item(CMD_READ, 63, 63, 1'b0);
      send_item(CMD_STEP, 0, 0, 1'b0);
    end
    set_grid(7'd64, 7'd64);
    send_item(CMD_READ, 3, 0, 1'b0);
    send_item(CMD_READ, 0, 3, 1'b0);
  endtask

  task automatic test_outside_kept();
    sender_steady = 1'b1;
    set_grid(7'd64, 7'd64);
    send_item(CMD_WRITE, 10, 10, 1'b1);
    send_item(CMD_WRITE, 10, 11, 1'b1);
    send_item(CMD_WRITE, 2, 20, 1'b1);
    send_item(CMD_WRITE, 2, 21, 1'b1);
    send_item(CMD_WRITE, 1, 1, 1'b1);
    send_item(CMD_WRITE, 1, 2, 1'b1);
    set_grid(7'd6, 7'd8);
    send_item(CMD_STEP, 0, 0, 1'b0);
    send_item(CMD_STEP, 0, 0, 1'b0);
    set_grid(7'd64, 7'd64);
    for (int r = 0; r < 4; r++) send_item(CMD_READ, ROW_AW'(r), COL_AW'(1 + r), 1'b0);
    send_item(CMD_READ, 10, 10, 1'b0);
    send_item(CMD_READ, 10, 11, 1'b0);
    send_item(CMD_READ, 2, 20, 1'b0);
    send_item(CMD_READ, 2, 21, 1'b0);
  endtask

  function automatic logic [EXT_W-1:0] pick_extent();
    case ($urandom_range(0, 11))
      0:       return 7'd64;
      1:       return 7'd3;
      2:       return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic send_probe(input cmd_t cmd);
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
    if ($urandom_range(0, 9) == 0) begin
      row = ROW_AW'($urandom_range(0, 63));
      col = COL_AW'($urandom_range(0, 63));
    end else begin
      row = ROW_AW'($urandom_range(0, rows_used - 1));
      col = COL_AW'($urandom_range(0, cols_used - 1));
    end
    if ($urandom_range(0, 24) == 0) cmd = CMD_NONE;
    send_item(cmd, row, col, $urandom_range(0, 99) < 40);
    random_sent++;
  endtask

  task automatic test_random_generations();
    int area, nwrites, nreads;
    while (random_sent < RANDOM_ITEMS) begin
      set_grid(pick_extent(), pick_extent());
      sender_steady = ($urandom_range(0, 3) == 0);
      rx_open = ($urandom_range(0, 4) == 0);
      area = rows_used * cols_used;
      nwrites = (area / 2 > 60) ? 60 : area / 2;
      nreads = (area / 2 > 30) ? 30 : area / 2;
      repeat (nwrites) send_probe(CMD_WRITE);
      repeat ($urandom_range(1, 4)) begin
        send_item(CMD_STEP, ROW_AW'($urandom_range(0, 63)), COL_AW'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)));
        random_sent++;
        repeat (nreads) send_probe(CMD_READ);
      end
    end
    rx_open = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_corner_cells();
    test_extent_limits();
    test_outside_kept();
    test_random_generations();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/seeds_pkg.sv
rtl/core/seeds_ram.sv
rtl/core/seeds_row_unit.sv
rtl/core/seeds_automaton_torus_step_top.sv
tb/sv/tb_top.sv
